@@ rtl/core/gkqs_pkg.sv @@
package gkqs_pkg;

  localparam int unsigned MAX_TUPLES_DEF = 64;
  localparam logic [6:0]  LIMIT_RESET    = 7'd64;
  localparam int unsigned LIMIT_FLOOR    = 3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        gap;
    logic [31:0]        delta;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SHIFT,
    OP_PLACE,
    OP_MSTART,
    OP_MSCAN,
    OP_MLAT,
    OP_MWRITE,
    OP_MSHIFT,
    OP_MDEC,
    OP_QSTART,
    OP_QSCAN,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    RS_IDX,
    RS_IDX_M1,
    RS_IDX_P1,
    RS_BEST
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rsel;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic empty;
    logic is_query;
    logic idx_zero;
    logic gt;
    logic scan_last;
    logic merge_due;
    logic best_zero;
    logic shift_end;
    logic found;
  } dp_stat_t;

endpackage

@@ rtl/core/gkqs_ram.sv @@
module gkqs_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/gkqs_dpath.sv @@
module gkqs_dpath
  import gkqs_pkg::*;
#(
  parameter int unsigned MAX_TUPLES = MAX_TUPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_type,
  input  logic signed [31:0] in_value,
  input  logic [16:0]        in_frac,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_limit,
  output logic signed [31:0] out_estimate,
  output logic [6:0]         out_held,
  output logic [1:0]         out_status
);

  localparam int unsigned IW   = (MAX_TUPLES > 1) ? $clog2(MAX_TUPLES) : 1;
  localparam int unsigned CW   = $clog2(MAX_TUPLES + 1);
  localparam int unsigned LW   = (CW > 7) ? CW : 7;
  localparam int unsigned CUMW = 33 + IW;
  localparam int unsigned CMPW = CUMW + 1;
  localparam int unsigned EW   = $bits(entry_t);

  logic [6:0]         limit;
  logic [CW-1:0]      count;
  logic [31:0]        obs;
  logic signed [31:0] val;
  logic               is_query;
  logic               placed;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      best;
  logic [33:0]        best_full;
  entry_t             prev;
  entry_t             succ;
  logic               have_succ;
  logic [48:0]        prod;
  logic [33:0]        rank;
  logic [CUMW-1:0]    cum;
  logic signed [31:0] est;

  logic [LW-1:0]      lim_raw;
  logic [LW-1:0]      lim;
  logic               drop;
  logic               empty;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;
  entry_t             rd;

  logic [32:0]        succ_sum;
  logic [31:0]        new_delta;
  logic [32:0]        merge_gap;
  logic [33:0]        fullness;
  logic               cand;
  logic [CUMW-1:0]    cur_incl;
  logic [CMPW-1:0]    reach;
  logic [49:0]        rank_sum;

  gkqs_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TUPLES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  // Limit in use is the written value clamped to the legal range.
  always_comb begin
    lim_raw = LW'(limit);
    if (lim_raw < LW'(LIMIT_FLOOR)) begin
      lim = LW'(LIMIT_FLOOR);
    end else if (lim_raw > LW'(MAX_TUPLES)) begin
      lim = LW'(MAX_TUPLES);
    end else begin
      lim = lim_raw;
    end
  end

  assign drop  = !is_query && (LW'(count) >= lim);
  assign empty = is_query && (count == '0);

  always_comb begin
    succ_sum  = {1'b0, succ.gap} + {1'b0, succ.delta};
    new_delta = 32'd0;
    if (have_succ && succ_sum != '0) begin
      new_delta = (succ_sum - 33'd1 > 33'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(succ_sum - 33'd1);
    end
    merge_gap = {1'b0, prev.gap} + {1'b0, rd.gap};
    fullness  = {2'b0, prev.gap} + {2'b0, rd.gap} + {2'b0, rd.delta};
    cand      = (idx >= CW'(2)) && (prev.delta >= rd.delta) && (fullness < best_full);
    cur_incl  = cum + CUMW'(prev.gap);
    reach     = {1'b0, cur_incl} + CMPW'(rd.gap);
    rank_sum  = {1'b0, prod} + 50'd65535;
  end

  always_comb begin
    stat.drop      = drop;
    stat.empty     = empty;
    stat.is_query  = is_query;
    stat.idx_zero  = (idx == '0);
    stat.gt        = rd.value > val;
    stat.scan_last = ((CW + 1)'(idx) + (CW + 1)'(1)) == (CW + 1)'(count);
    stat.merge_due = LW'(count) >= lim;
    stat.best_zero = (best == '0);
    stat.shift_end = ((CW + 1)'(idx) + (CW + 1)'(1)) >= (CW + 1)'(count);
    stat.found     = (idx != '0) && (reach > CMPW'(rank));
  end

  always_comb begin
    unique case (cmd.rsel)
      RS_IDX:    ram_raddr = idx[IW-1:0];
      RS_IDX_M1: ram_raddr = IW'(idx - CW'(1));
      RS_IDX_P1: ram_raddr = IW'(idx + CW'(1));
      RS_BEST:   ram_raddr = best[IW-1:0];
      default:   ram_raddr = idx[IW-1:0];
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = rd;
    case (cmd.op)
      OP_SHIFT: ram_we = stat.gt;
      OP_PLACE: begin
        ram_we    = 1'b1;
        ram_wdata = '{value: val, gap: 32'd1, delta: new_delta};
      end
      OP_MWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = best[IW-1:0];
        ram_wdata = '{value: rd.value,
                      gap: merge_gap[32] ? 32'hFFFFFFFF : merge_gap[31:0],
                      delta: rd.delta};
      end
      OP_MSHIFT: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      count <= '0;
      obs   <= '0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_limit;
      end
      case (cmd.op)
        OP_PLACE: begin
          count <= count + CW'(1);
          if (obs != 32'hFFFFFFFF) begin
            obs <= obs + 32'd1;
          end
        end
        OP_MDEC: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        val       <= in_value;
        is_query  <= in_type;
        placed    <= 1'b0;
        idx       <= count;
        have_succ <= 1'b0;
        est       <= '0;
        prod      <= 49'(in_frac) * 49'(obs);
      end
      OP_SHIFT: begin
        if (stat.gt) begin
          succ      <= rd;
          have_succ <= 1'b1;
          idx       <= idx - CW'(1);
        end
      end
      OP_PLACE: placed <= 1'b1;
      OP_MSTART: begin
        idx       <= CW'(1);
        best      <= '0;
        best_full <= '1;
      end
      OP_MSCAN: begin
        if (cand) begin
          best      <= idx - CW'(1);
          best_full <= fullness;
        end
        prev <= rd;
        idx  <= idx + CW'(1);
      end
      OP_MLAT: begin
        prev <= rd;
        idx  <= best + CW'(1);
      end
      OP_MSHIFT: idx <= idx + CW'(1);
      OP_QSTART: begin
        rank <= rank_sum[49:16];
        idx  <= '0;
        cum  <= '0;
      end
      OP_QSCAN: begin
        if (idx == '0) begin
          prev <= rd;
          est  <= rd.value;
        end else if (stat.found) begin
          est <= prev.value;
        end else begin
          cum  <= cur_incl;
          prev <= rd;
          est  <= rd.value;
        end
        idx <= idx + CW'(1);
      end
      OP_OUT: begin
        out_estimate <= est;
        out_held     <= 7'(count);
        // An insert that never reached the placement step was dropped; a full
        // store after a successful insert is still a normal result.
        if (!is_query && !placed) begin
          out_status <= ST_DROP;
        end else if (empty) begin
          out_status <= ST_EMPTY;
        end else begin
          out_status <= ST_OK;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/gkqs_ctrl.sv @@
module gkqs_ctrl
  import gkqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_QSTART,
    S_Q_RD,
    S_Q_SCAN,
    S_INS_CHK,
    S_INS_CMP,
    S_PLACE,
    S_MCHK,
    S_M_RD,
    S_M_SCAN,
    S_M_EVAL,
    S_M_LAT,
    S_M_RD2,
    S_M_WR,
    S_M_SHCHK,
    S_M_SH,
    S_M_END,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd.op         = OP_NONE;
    cmd.rsel       = RS_IDX;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.drop || stat.empty) begin
          state_next = S_FIN;
        end else if (stat.is_query) begin
          state_next = S_QSTART;
        end else begin
          state_next = S_INS_CHK;
        end
      end
      S_QSTART: begin
        cmd.op     = OP_QSTART;
        state_next = S_Q_RD;
      end
      S_Q_RD: state_next = S_Q_SCAN;
      S_Q_SCAN: begin
        cmd.op     = OP_QSCAN;
        state_next = (stat.found || stat.scan_last) ? S_FIN : S_Q_RD;
      end
      // Insertion walks down from the end, moving each larger tuple up one slot.
      S_INS_CHK: begin
        if (stat.idx_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rsel   = RS_IDX_M1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.op     = OP_SHIFT;
        state_next = stat.gt ? S_INS_CHK : S_PLACE;
      end
      S_PLACE: begin
        cmd.op     = OP_PLACE;
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (stat.merge_due) begin
          cmd.op     = OP_MSTART;
          state_next = S_M_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_M_RD: state_next = S_M_SCAN;
      S_M_SCAN: begin
        cmd.op     = OP_MSCAN;
        state_next = stat.scan_last ? S_M_EVAL : S_M_RD;
      end
      S_M_EVAL: begin
        if (stat.best_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.rsel   = RS_BEST;
          state_next = S_M_LAT;
        end
      end
      S_M_LAT: begin
        cmd.op     = OP_MLAT;
        state_next = S_M_RD2;
      end
      S_M_RD2: state_next = S_M_WR;
      S_M_WR: begin
        cmd.op     = OP_MWRITE;
        state_next = S_M_SHCHK;
      end
      S_M_SHCHK: begin
        if (stat.shift_end) begin
          state_next = S_M_END;
        end else begin
          cmd.rsel   = RS_IDX_P1;
          state_next = S_M_SH;
        end
      end
      S_M_SH: begin
        cmd.op     = OP_MSHIFT;
        state_next = S_M_SHCHK;
      end
      S_M_END: begin
        cmd.op     = OP_MDEC;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/core/gk_quantile_sketch_unit.sv @@
// Quantile sketch over a stream of signed 32-bit samples.
// Input channel s_*: one request per handshake. s_tuser selects the kind:
// 0 inserts s_tdata sample_value, 1 asks for the quantile at quant_fraction
// (Q1.16, 65536 is 1.0). Output channel m_*: one result per request, in order,
// carrying the estimate, the tuple count after the request and a status code.
// The cfg_* channel writes the tuple limit; it is always ready and should only
// be written while no request is in flight.
// One request is worked at a time against a tuple memory with one read port,
// one write port and a registered read. An insert moves each larger tuple up,
// places the sample and, at the limit, scans for the best pair, merges it and
// shifts the tuples above it down; a query walks the tuples until its rank is reached.
// A new request is taken as soon as the previous result sits in the output
// register, even if the receiver has not taken it yet. When the receiver
// stalls with a result still held, the next finished result waits inside.
// Reset empties the store, clears the observation count and sets the limit
// to 64; memory contents are not cleared.
module gk_quantile_sketch_unit
  import gkqs_pkg::*;
#(
  parameter int unsigned MAX_TUPLES = MAX_TUPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sample_value[31:0], quant_fraction[48:32], zero pad
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // estimate[31:0], tuples_held[38:32], status[40:39], pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic signed [31:0] estimate;
  logic [6:0]         tuples_held;
  logic [1:0]         status;

  assign cfg_ready = 1'b1;

  gkqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gkqs_dpath #(
    .MAX_TUPLES(MAX_TUPLES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_type     (s_tuser),
    .in_value    (s_tdata[31:0]),
    .in_frac     (s_tdata[48:32]),
    .cfg_we      (cfg_valid),
    .cfg_limit   (cfg_data),
    .out_estimate(estimate),
    .out_held    (tuples_held),
    .out_status  (status)
  );

  assign m_tdata = {7'd0, status, tuples_held, estimate};

endmodule
